// File: hdl/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg: shared types and constants for the RGBC color classifier
// Holds channel widths, scaling constants, divider sizes, color codes and the
// side-band records that travel alongside the pipelined dividers.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int CH_W       = 16;
  localparam int PROD_W     = 32;
  localparam int DEN_W      = 23;
  localparam int SCALE_Q_W  = 16;
  localparam int FRAC_Q_W   = 8;
  localparam int HUE_W      = 9;
  localparam int SAT_W      = 8;
  localparam int CODE_W     = 3;
  localparam int T_W        = 21;

  localparam logic [CH_W-1:0]  SCALE_MUL = 16'd65025;
  localparam logic [DEN_W-1:0] CLEAR_MUL = 23'd88;

  localparam logic [CODE_W-1:0] CODE_NONE   = 3'd0;
  localparam logic [CODE_W-1:0] CODE_RED    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_GREEN  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_BLUE   = 3'd3;
  localparam logic [CODE_W-1:0] CODE_YELLOW = 3'd4;
  localparam logic [CODE_W-1:0] CODE_PURPLE = 3'd5;
  localparam logic [CODE_W-1:0] CODE_WHITE  = 3'd6;

  typedef struct packed {
    logic [CH_W-1:0] clear_raw;
    logic            zero;
    logic            sat;
  } scale_tag_t;

  typedef struct packed {
    logic [HUE_W-1:0] base;
    logic [CH_W-1:0]  mx;
    logic [T_W-1:0]   t;
    logic             dz;
    logic             zero;
  } hue_tag_t;

endpackage

// File: hdl/ccr_divider.sv
// ----------------------------------------------------------------------------
// ccr_divider: pipelined restoring divider
// One quotient bit per register stage. The upper DIV_W bits of the dividend
// must be below the divisor, so the quotient fits in QUO_W bits. A side-band
// tag travels with each operand pair; all stages advance together on en.
// ----------------------------------------------------------------------------
module ccr_divider #(
  parameter int QUO_W = ccr_pkg::FRAC_Q_W,
  parameter int DIV_W = ccr_pkg::CH_W,
  parameter int TAG_W = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [QUO_W+DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0]       divisor,
  input  logic [TAG_W-1:0]       in_tag,
  output logic                   out_valid,
  output logic [QUO_W-1:0]       quotient,
  output logic [TAG_W-1:0]       out_tag
);

  logic [QUO_W-1:0] vld;
  logic [DIV_W-1:0] rem  [QUO_W-1];
  logic [DIV_W-1:0] dsr  [QUO_W-1];
  logic [QUO_W-1:0] bits [QUO_W];
  logic [TAG_W-1:0] tag  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic             vld_prev;
    logic [DIV_W-1:0] rem_prev;
    logic [DIV_W-1:0] dsr_prev;
    logic [QUO_W-1:0] bits_prev;
    logic [TAG_W-1:0] tag_prev;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic [DIV_W-1:0] rem_next;
    logic [QUO_W-1:0] bits_next;

    if (k == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign rem_prev  = dividend[QUO_W+DIV_W-1:QUO_W];
      assign dsr_prev  = divisor;
      assign bits_prev = dividend[QUO_W-1:0];
      assign tag_prev  = in_tag;
    end else begin : g_rest
      assign vld_prev  = vld[k-1];
      assign rem_prev  = rem[k-1];
      assign dsr_prev  = dsr[k-1];
      assign bits_prev = bits[k-1];
      assign tag_prev  = tag[k-1];
    end

    always_comb begin
      trial     = {rem_prev, bits_prev[QUO_W-1]};
      diff      = trial - {1'b0, dsr_prev};
      bits_next = bits_prev << 1;
      if (trial >= {1'b0, dsr_prev}) begin
        rem_next     = diff[DIV_W-1:0];
        bits_next[0] = 1'b1;
      end else begin
        rem_next = trial[DIV_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bits[k] <= bits_next;
        tag[k]  <= tag_prev;
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= rem_next;
          dsr[k] <= dsr_prev;
        end
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quotient  = bits[QUO_W-1];
  assign out_tag   = tag[QUO_W-1];

endmodule

// File: hdl/color_class_from_rgbc.sv
// ----------------------------------------------------------------------------
// color_class_from_rgbc: RGBC sample to HSV and color code
// A sample enters on the sample channel (red_raw, green_raw, blue_raw,
// clear_raw) with sample_valid; it transfers when sample_stall is low.
// Each transfer yields exactly one result on the result channel
// (color_code, hue_deg, saturation, value_level), taken when result_valid is
// high and result_stall is low.
// The channels are normalized by the clear count through three 16-stage
// pipelined dividers, then hue and saturation come from two 8-stage dividers
// running side by side. One sample is accepted every cycle while sample_stall
// is low; the divider stages set the latency, not the throughput.
// The whole pipeline advances as one. While a result waits and result_stall
// is high, every stage holds and sample_stall is raised, so nothing is lost
// or repeated. Bubbles are not squeezed out during a stall.
// Reset clears all stage valid bits; the first result appears only after a
// new sample has passed through. A zero clear count gives an all-zero result.
// ----------------------------------------------------------------------------
module color_class_from_rgbc (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic [ccr_pkg::CH_W-1:0]     red_raw,
  input  logic [ccr_pkg::CH_W-1:0]     green_raw,
  input  logic [ccr_pkg::CH_W-1:0]     blue_raw,
  input  logic [ccr_pkg::CH_W-1:0]     clear_raw,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [ccr_pkg::CODE_W-1:0]   color_code,
  output logic [ccr_pkg::HUE_W-1:0]    hue_deg,
  output logic [ccr_pkg::SAT_W-1:0]    saturation,
  output logic [ccr_pkg::CH_W-1:0]     value_level
);

  localparam int CH_W   = ccr_pkg::CH_W;
  localparam int PROD_W = ccr_pkg::PROD_W;
  localparam int DEN_W  = ccr_pkg::DEN_W;
  localparam int HUE_W  = ccr_pkg::HUE_W;
  localparam int SAT_W  = ccr_pkg::SAT_W;
  localparam int CODE_W = ccr_pkg::CODE_W;
  localparam int T_W    = ccr_pkg::T_W;
  localparam int SQ_W   = ccr_pkg::SCALE_Q_W;
  localparam int FQ_W   = ccr_pkg::FRAC_Q_W;

  logic adv;

  assign adv          = !(result_valid && result_stall);
  assign sample_stall = !adv;

  // Stage 1: products for the normalizing division.
  logic              s1_valid;
  logic [PROD_W-1:0] s1_prod_r;
  logic [PROD_W-1:0] s1_prod_g;
  logic [PROD_W-1:0] s1_prod_b;
  logic [DEN_W-1:0]  s1_den;
  logic [CH_W-1:0]   s1_clear;
  logic              s1_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r <= PROD_W'(red_raw) * PROD_W'(ccr_pkg::SCALE_MUL);
      s1_prod_g <= PROD_W'(green_raw) * PROD_W'(ccr_pkg::SCALE_MUL);
      s1_prod_b <= PROD_W'(blue_raw) * PROD_W'(ccr_pkg::SCALE_MUL);
      s1_den    <= DEN_W'(clear_raw) * ccr_pkg::CLEAR_MUL;
      s1_clear  <= clear_raw;
      s1_zero   <= (clear_raw == '0);
    end
  end

  // A quotient of 2^16 or more saturates; the dividers then run on don't-care data.
  logic                sat_r;
  logic                sat_g;
  logic                sat_b;
  ccr_pkg::scale_tag_t red_tag_in;
  ccr_pkg::scale_tag_t red_tag_out;
  logic                sat_g_out;
  logic                sat_b_out;
  logic                div_r_valid;
  logic [SQ_W-1:0]     quo_r;
  logic [SQ_W-1:0]     quo_g;
  logic [SQ_W-1:0]     quo_b;

  assign sat_r = DEN_W'(s1_prod_r[PROD_W-1:SQ_W]) >= s1_den;
  assign sat_g = DEN_W'(s1_prod_g[PROD_W-1:SQ_W]) >= s1_den;
  assign sat_b = DEN_W'(s1_prod_b[PROD_W-1:SQ_W]) >= s1_den;

  assign red_tag_in.clear_raw = s1_clear;
  assign red_tag_in.zero      = s1_zero;
  assign red_tag_in.sat       = sat_r;

  ccr_divider #(
    .QUO_W (SQ_W),
    .DIV_W (DEN_W),
    .TAG_W ($bits(ccr_pkg::scale_tag_t))
  ) u_div_r (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_valid),
    .dividend  ((SQ_W+DEN_W)'(s1_prod_r)),
    .divisor   (s1_den),
    .in_tag    (red_tag_in),
    .out_valid (div_r_valid),
    .quotient  (quo_r),
    .out_tag   (red_tag_out)
  );

  ccr_divider #(
    .QUO_W (SQ_W),
    .DIV_W (DEN_W),
    .TAG_W (1)
  ) u_div_g (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_valid),
    .dividend  ((SQ_W+DEN_W)'(s1_prod_g)),
    .divisor   (s1_den),
    .in_tag    (sat_g),
    .out_valid (),
    .quotient  (quo_g),
    .out_tag   (sat_g_out)
  );

  ccr_divider #(
    .QUO_W (SQ_W),
    .DIV_W (DEN_W),
    .TAG_W (1)
  ) u_div_b (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_valid),
    .dividend  ((SQ_W+DEN_W)'(s1_prod_b)),
    .divisor   (s1_den),
    .in_tag    (sat_b),
    .out_valid (),
    .quotient  (quo_b),
    .out_tag   (sat_b_out)
  );

  // Stage 3: saturated, normalized channels.
  logic            s3_valid;
  logic [CH_W-1:0] s3_r;
  logic [CH_W-1:0] s3_g;
  logic [CH_W-1:0] s3_b;
  logic [CH_W-1:0] s3_clear;
  logic            s3_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= div_r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r     <= red_tag_out.sat ? '1 : quo_r;
      s3_g     <= sat_g_out ? '1 : quo_g;
      s3_b     <= sat_b_out ? '1 : quo_b;
      s3_clear <= red_tag_out.clear_raw;
      s3_zero  <= red_tag_out.zero;
    end
  end

  // Stage 4: max, min, which channel is the minimum, brightness partial sums.
  logic            s4_valid;
  logic [CH_W-1:0] s4_r;
  logic [CH_W-1:0] s4_g;
  logic [CH_W-1:0] s4_b;
  logic [CH_W-1:0] s4_mx;
  logic [CH_W-1:0] s4_mn;
  logic            s4_rmin;
  logic            s4_gmin;
  logic [T_W-2:0]  s4_ta;
  logic [T_W-3:0]  s4_tb;
  logic            s4_zero;
  logic [CH_W-1:0] mx_rg;
  logic [CH_W-1:0] mn_rg;
  logic            rmin_next;

  assign mx_rg     = (s3_r > s3_g) ? s3_r : s3_g;
  assign mn_rg     = (s3_r < s3_g) ? s3_r : s3_g;
  assign rmin_next = (s3_r <= s3_g) && (s3_r <= s3_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r    <= s3_r;
      s4_g    <= s3_g;
      s4_b    <= s3_b;
      s4_mx   <= (s3_b > mx_rg) ? s3_b : mx_rg;
      s4_mn   <= (s3_b < mn_rg) ? s3_b : mn_rg;
      s4_rmin <= rmin_next;
      s4_gmin <= !rmin_next && (s3_g <= s3_b);
      s4_ta   <= ((T_W-1)'(s3_clear) << 3) + ((T_W-1)'(s3_clear) << 1)
                 + ((T_W-1)'(s3_r) << 1) + (T_W-1)'(s3_r);
      s4_tb   <= ((T_W-2)'(s3_g) << 1) + (T_W-2)'(s3_g) + ((T_W-2)'(s3_b) << 2);
      s4_zero <= s3_zero;
    end
  end

  // Stage 5: spread, hue offset term and sector base, full brightness.
  logic               s5_valid;
  logic [CH_W-1:0]    s5_d;
  logic signed [CH_W:0] s5_f;
  logic [HUE_W-1:0]   s5_base;
  logic [T_W-1:0]     s5_t;
  logic [CH_W-1:0]    s5_mx;
  logic               s5_zero;
  logic signed [CH_W:0] f_next;
  logic [HUE_W-1:0]   base_next;

  always_comb begin
    if (s4_rmin) begin
      f_next    = $signed({1'b0, s4_g}) - $signed({1'b0, s4_b});
      base_next = HUE_W'(120);
    end else if (s4_gmin) begin
      f_next    = $signed({1'b0, s4_b}) - $signed({1'b0, s4_r});
      base_next = HUE_W'(240);
    end else begin
      f_next    = $signed({1'b0, s4_r}) - $signed({1'b0, s4_g});
      base_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_d    <= s4_mx - s4_mn;
      s5_f    <= f_next;
      s5_base <= base_next;
      s5_t    <= T_W'(s4_ta) + T_W'(s4_tb);
      s5_mx   <= s4_mx;
      s5_zero <= s4_zero;
    end
  end

  // Stage 6: hue numerator term, scaled spread and the saturation threshold.
  logic                   s6_valid;
  logic [CH_W:0]          s6_e;
  logic [CH_W-1:0]        s6_d;
  logic [CH_W+FQ_W-1:0]   s6_dx255;
  logic [CH_W+FQ_W-1:0]   s6_mx80;
  logic [CH_W-1:0]        s6_mx;
  logic [HUE_W-1:0]       s6_base;
  logic [T_W-1:0]         s6_t;
  logic                   s6_zero;
  logic signed [CH_W+1:0] e_full;

  assign e_full = $signed({2'b00, s5_d}) - $signed({s5_f[CH_W], s5_f});

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_e     <= e_full[CH_W:0];
      s6_d     <= s5_d;
      s6_dx255 <= ((CH_W+FQ_W)'(s5_d) << FQ_W) - (CH_W+FQ_W)'(s5_d);
      s6_mx80  <= ((CH_W+FQ_W)'(s5_mx) << 6) + ((CH_W+FQ_W)'(s5_mx) << 4);
      s6_mx    <= s5_mx;
      s6_base  <= s5_base;
      s6_t     <= s5_t;
      s6_zero  <= s5_zero;
    end
  end

  // Hue and saturation dividers, kept in step.
  logic [CH_W+FQ_W-1:0] hue_num;
  logic                 sat80;
  ccr_pkg::hue_tag_t    hue_tag_in;
  ccr_pkg::hue_tag_t    hue_tag_out;
  logic                 sat80_out;
  logic                 div_h_valid;
  logic [FQ_W-1:0]      quo_h;
  logic [FQ_W-1:0]      quo_s;

  assign hue_num = ((CH_W+FQ_W)'(s6_e) << 6) - ((CH_W+FQ_W)'(s6_e) << 2);
  assign sat80   = s6_dx255 > s6_mx80;

  assign hue_tag_in.base = s6_base;
  assign hue_tag_in.mx   = s6_mx;
  assign hue_tag_in.t    = s6_t;
  assign hue_tag_in.dz   = (s6_d == '0);
  assign hue_tag_in.zero = s6_zero;

  ccr_divider #(
    .QUO_W (FQ_W),
    .DIV_W (CH_W),
    .TAG_W ($bits(ccr_pkg::hue_tag_t))
  ) u_div_hue (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s6_valid),
    .dividend  (hue_num),
    .divisor   (s6_d),
    .in_tag    (hue_tag_in),
    .out_valid (div_h_valid),
    .quotient  (quo_h),
    .out_tag   (hue_tag_out)
  );

  ccr_divider #(
    .QUO_W (FQ_W),
    .DIV_W (CH_W),
    .TAG_W (1)
  ) u_div_sat (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s6_valid),
    .dividend  (s6_dx255),
    .divisor   (s6_mx),
    .in_tag    (sat80),
    .out_valid (),
    .quotient  (quo_s),
    .out_tag   (sat80_out)
  );

  // Stage 7: final hue and saturation.
  logic             s7_valid;
  logic [HUE_W-1:0] s7_h;
  logic [SAT_W-1:0] s7_s;
  logic [CH_W-1:0]  s7_mx;
  logic [T_W-1:0]   s7_t;
  logic             s7_sat80;
  logic             s7_zero;
  logic [HUE_W:0]   hue_sum;
  logic [HUE_W-1:0] hue_next;

  always_comb begin
    hue_sum = (HUE_W+1)'(hue_tag_out.base) + (HUE_W+1)'(quo_h);
    if (hue_tag_out.dz) begin
      hue_next = '0;
    end else if (hue_sum >= (HUE_W+1)'(360)) begin
      hue_next = HUE_W'(hue_sum - (HUE_W+1)'(360));
    end else begin
      hue_next = hue_sum[HUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (adv) begin
      s7_valid <= div_h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_h     <= hue_next;
      s7_s     <= hue_tag_out.dz ? '0 : SAT_W'(quo_s);
      s7_mx    <= hue_tag_out.mx;
      s7_t     <= hue_tag_out.t;
      s7_sat80 <= sat80_out;
      s7_zero  <= hue_tag_out.zero;
    end
  end

  // Stage 8: color windows and the result register.
  logic [CODE_W-1:0] code_next;

  always_comb begin
    code_next = ccr_pkg::CODE_NONE;
    if (s7_t > T_W'(2700)) begin
      if (s7_mx > CH_W'(255)) begin
        if (s7_h > HUE_W'(20) && s7_h < HUE_W'(50) && s7_sat80) begin
          code_next = ccr_pkg::CODE_YELLOW;
        end else if (s7_h <= HUE_W'(13) || s7_h > HUE_W'(345)) begin
          code_next = ccr_pkg::CODE_RED;
        end else if (s7_h > HUE_W'(220) && s7_h < HUE_W'(345)) begin
          code_next = ccr_pkg::CODE_PURPLE;
        end else if (s7_h > HUE_W'(160) && s7_h <= HUE_W'(220)) begin
          code_next = ccr_pkg::CODE_BLUE;
        end else if (s7_h > HUE_W'(50) && s7_h <= HUE_W'(80) && s7_t >= T_W'(2900)
                     && s7_mx < CH_W'(270)) begin
          code_next = ccr_pkg::CODE_WHITE;
        end else if (s7_h > HUE_W'(50) && s7_h <= HUE_W'(127) && s7_mx > CH_W'(270)) begin
          code_next = ccr_pkg::CODE_GREEN;
        end
      end
      if (code_next == ccr_pkg::CODE_NONE && s7_mx < CH_W'(270)) begin
        if (s7_h > HUE_W'(15) && s7_h <= HUE_W'(30) && s7_t >= T_W'(2900)) begin
          code_next = ccr_pkg::CODE_WHITE;
        end else if ((s7_h > HUE_W'(220) && s7_h < HUE_W'(345)) || s7_h <= HUE_W'(60)) begin
          code_next = ccr_pkg::CODE_PURPLE;
        end
      end
    end
    if (code_next == ccr_pkg::CODE_NONE && s7_t > T_W'(2530) && s7_h > HUE_W'(50)
        && s7_h <= HUE_W'(127) && s7_mx > CH_W'(270)) begin
      code_next = ccr_pkg::CODE_GREEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      color_code  <= s7_zero ? ccr_pkg::CODE_NONE : code_next;
      hue_deg     <= s7_zero ? '0 : s7_h;
      saturation  <= s7_zero ? '0 : s7_s;
      value_level <= s7_zero ? '0 : s7_mx;
    end
  end

`ifndef SYNTHESIS
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> hue_deg < HUE_W'(360))
    else $error("hue out of range");

  a_black_is_flat: assert property (@(posedge clk) disable iff (rst)
    result_valid && value_level == '0 |-> hue_deg == '0 && saturation == '0)
    else $error("nonzero hue or saturation with zero value");

  a_red_window: assert property (@(posedge clk) disable iff (rst)
    result_valid && color_code == ccr_pkg::CODE_RED
      |-> hue_deg <= HUE_W'(13) || hue_deg > HUE_W'(345))
    else $error("red code outside its hue window");

  a_yellow_window: assert property (@(posedge clk) disable iff (rst)
    result_valid && color_code == ccr_pkg::CODE_YELLOW
      |-> saturation >= SAT_W'(80) && hue_deg > HUE_W'(20) && hue_deg < HUE_W'(50))
    else $error("yellow code outside its hue or saturation window");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    s7_valid && result_valid && result_stall |=> s7_valid)
    else $error("pipeline stage lost an item during a stall");
`endif

endmodule
